// File: hdl/fne_pkg.sv
// fne_pkg: shared types and constants of the FASTA nucleotide encoder.
// Used by the channel interfaces and by every module of the block.
// No dependencies.
`timescale 1ns / 1ps

package fne_pkg;

  // Default width of every counter and position register
  localparam int COUNT_BITS_DEFAULT = 32;
  // Width of the counter and position fields on the result channel
  localparam int FIELD_BITS = 32;
  // Entries in the queue between the front and back parts
  localparam int QUEUE_DEPTH = 2;

  // Byte classes; the four bases share their values with their symbol codes
  typedef enum logic [2:0] {
    CLS_A     = 3'd0,
    CLS_C     = 3'd1,
    CLS_G     = 3'd2,
    CLS_T     = 3'd3,
    CLS_WILD  = 3'd4,
    CLS_SPACE = 3'd6,
    CLS_BAD   = 3'd7
  } cls_t;

  // Symbol codes that are not bases
  localparam logic [2:0] CODE_NONE = 3'd0;
  localparam logic [2:0] CODE_WILD = 3'd4;
  localparam logic [2:0] CODE_SEP  = 3'd5;

  // One classified byte as it travels through the queue
  typedef struct packed {
    cls_t cls;
    logic is_gt;
    logic is_nl;
    logic last;
  } op_t;

  // Front to queue
  typedef struct packed {
    logic push;
    op_t  op;
  } q_wr_t;

  // Queue to back
  typedef struct packed {
    logic valid;
    op_t  op;
  } q_rd_t;

endpackage

// File: hdl/fne_if.sv
// Channel interfaces of the FASTA nucleotide encoder: byte input and result output.
// Depends on fne_pkg for the field widths.
`timescale 1ns / 1ps

interface fne_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;

  modport source (output valid, output data_byte, output last_byte, input ready);
  modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface fne_out_if;
  logic                          valid;
  logic                          ready;
  logic                          sym_valid;
  logic [2:0]                    sym_code;
  logic                          range_valid;
  logic [fne_pkg::FIELD_BITS-1:0] range_start;
  logic [fne_pkg::FIELD_BITS-1:0] range_length;
  logic                          error;
  logic [fne_pkg::FIELD_BITS-1:0] count_a;
  logic [fne_pkg::FIELD_BITS-1:0] count_c;
  logic [fne_pkg::FIELD_BITS-1:0] count_g;
  logic [fne_pkg::FIELD_BITS-1:0] count_t;
  logic [fne_pkg::FIELD_BITS-1:0] special_count;
  logic [fne_pkg::FIELD_BITS-1:0] total_length;

  modport source (
    output valid, output sym_valid, output sym_code, output range_valid,
    output range_start, output range_length, output error,
    output count_a, output count_c, output count_g, output count_t,
    output special_count, output total_length,
    input ready
  );
  modport sink (
    input valid, input sym_valid, input sym_code, input range_valid,
    input range_start, input range_length, input error,
    input count_a, input count_c, input count_g, input count_t,
    input special_count, input total_length,
    output ready
  );
endinterface

// File: hdl/fasta_nucleotide_encoder_unit.sv
// FASTA nucleotide encoder, top level.
// Channel "fasta" (sink) takes one file byte per beat with its last_byte mark.
// Channel "symbols" (source) gives exactly one result beat per byte: the
// symbol it produced (if any), a closed special run (if any), the sticky
// error flag and the running counts taken after that byte.
// A byte beat is classified and written into a two-entry queue; the back
// part takes one entry per cycle while the result register is free or being
// drained, updates the line state and counters and loads the result register.
// Throughput is one byte per cycle while the receiver does not stall.
// When the receiver stalls, the result register holds its beat and the queue
// fills; fasta.ready drops only once both queue entries are taken.
// Reset (rst, synchronous, active high) empties the queue and the result
// register and clears all line state and counters. The byte marked last is
// encoded normally, then the state returns to its reset values for the next
// file. Counters and positions saturate at 2^COUNT_BITS - 1.
// Depends on fne_pkg, fne_if, fne_front, fne_queue and fne_back.
`timescale 1ns / 1ps

module fasta_nucleotide_encoder_unit #(
  parameter int COUNT_BITS = fne_pkg::COUNT_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  fne_in_if.sink     fasta,
  fne_out_if.source  symbols
);
  import fne_pkg::*;

  q_wr_t wr;
  q_rd_t rd;
  logic  full;
  logic  pop;

  // Byte intake and classification
  fne_front u_front (
    .fasta (fasta),
    .full  (full),
    .wr    (wr)
  );

  // Decoupling queue
  fne_queue u_queue (
    .clk  (clk),
    .rst  (rst),
    .wr   (wr),
    .pop  (pop),
    .rd   (rd),
    .full (full)
  );

  // Encoding, counters and result register
  fne_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .rd      (rd),
    .pop     (pop),
    .symbols (symbols)
  );

endmodule

// File: hdl/fne_front.sv
// fne_front: accepts byte beats and classifies each byte for the queue.
// Depends on fne_pkg and fne_in_if.
`timescale 1ns / 1ps

module fne_front (
  fne_in_if.sink          fasta,
  input  logic            full,
  output fne_pkg::q_wr_t  wr
);
  import fne_pkg::*;

  // Map a raw byte to its class
  function automatic cls_t classify(input logic [7:0] b);
    cls_t c;
    case (b)
      "A", "a":           c = CLS_A;
      "C", "c":           c = CLS_C;
      "G", "g":           c = CLS_G;
      "T", "t", "U", "u": c = CLS_T;
      "N", "S", "Y", "W", "R", "K", "V", "B", "D", "H", "M",
      "n", "s", "y", "w", "r", "k", "v", "b", "d", "h", "m":
                          c = CLS_WILD;
      8'h20, 8'h09, 8'h0A, 8'h0B, 8'h0C, 8'h0D:
                          c = CLS_SPACE;
      default:            c = CLS_BAD;
    endcase
    return c;
  endfunction

  // Take a beat whenever the queue has room
  assign fasta.ready = !full;

  always_comb begin
    wr.push     = fasta.valid && !full;
    wr.op.cls   = classify(fasta.data_byte);
    wr.op.is_gt = (fasta.data_byte == ">");
    wr.op.is_nl = (fasta.data_byte == 8'h0A);
    wr.op.last  = fasta.last_byte;
  end

endmodule

// File: hdl/fne_queue.sv
// fne_queue: short FIFO of classified bytes between the front and back parts.
// Depends on fne_pkg.
`timescale 1ns / 1ps

module fne_queue (
  input  logic            clk,
  input  logic            rst,
  input  fne_pkg::q_wr_t  wr,
  input  logic            pop,
  output fne_pkg::q_rd_t  rd,
  output logic            full
);
  import fne_pkg::*;

  localparam int PtrBits = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CntBits = $clog2(QUEUE_DEPTH + 1);

  op_t                slots [QUEUE_DEPTH];
  logic [PtrBits-1:0] wr_ptr;
  logic [PtrBits-1:0] rd_ptr;
  logic [CntBits-1:0] fill;

  function automatic logic [PtrBits-1:0] ptr_inc(input logic [PtrBits-1:0] p);
    return (p == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  assign full     = (fill == CntBits'(QUEUE_DEPTH));
  assign rd.valid = (fill != '0);
  assign rd.op    = slots[rd_ptr];

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (wr.push) wr_ptr <= ptr_inc(wr_ptr);
      if (pop)     rd_ptr <= ptr_inc(rd_ptr);
      if (wr.push && !pop)      fill <= fill + 1'b1;
      else if (pop && !wr.push) fill <= fill - 1'b1;
    end
  end

  // Storage
  always_ff @(posedge clk) begin
    if (wr.push) slots[wr_ptr] <= wr.op;
  end

endmodule

// File: hdl/fne_back.sv
// fne_back: line state machine, symbol encoding, run tracking, counters and result register.
// Depends on fne_pkg and fne_out_if.
`timescale 1ns / 1ps

module fne_back #(
  parameter int COUNT_BITS = fne_pkg::COUNT_BITS_DEFAULT
) (
  input  logic            clk,
  input  logic            rst,
  input  fne_pkg::q_rd_t  rd,
  output logic            pop,
  fne_out_if.source       symbols
);
  import fne_pkg::*;

  typedef enum logic [2:0] {
    MODE_START  = 3'b001,
    MODE_HEADER = 3'b010,
    MODE_SEQ    = 3'b100
  } mode_t;

  typedef struct packed {
    logic                  sym_valid;
    logic [2:0]            sym_code;
    logic                  range_valid;
    logic [FIELD_BITS-1:0] range_start;
    logic [FIELD_BITS-1:0] range_length;
    logic                  error;
    logic [FIELD_BITS-1:0] count_a;
    logic [FIELD_BITS-1:0] count_c;
    logic [FIELD_BITS-1:0] count_g;
    logic [FIELD_BITS-1:0] count_t;
    logic [FIELD_BITS-1:0] special_count;
    logic [FIELD_BITS-1:0] total_length;
  } res_t;

  function automatic logic [COUNT_BITS-1:0] sat_inc(input logic [COUNT_BITS-1:0] v);
    return (&v) ? v : v + 1'b1;
  endfunction

  mode_t                 mode, mode_next;
  logic                  header_seen, header_seen_next;
  logic [COUNT_BITS-1:0] run_length, run_length_next;
  logic [COUNT_BITS-1:0] run_start, run_start_next;
  logic [COUNT_BITS-1:0] base_counts [4];
  logic [COUNT_BITS-1:0] base_counts_next [4];
  logic [COUNT_BITS-1:0] special_total, special_total_next;
  logic [COUNT_BITS-1:0] emitted_length, emitted_length_next;
  logic                  error_latch, error_latch_next;

  logic                  out_valid;
  res_t                  res, res_next;
  logic [2:0]            cls_bits;
  logic                  take_special;
  logic                  sym_valid;
  logic [2:0]            sym_code;
  logic                  range_valid;
  logic [COUNT_BITS-1:0] range_start;
  logic [COUNT_BITS-1:0] range_length;

  // Work on the head of the queue when the result register is free or being drained
  assign pop      = rd.valid && (!out_valid || symbols.ready);
  assign cls_bits = rd.op.cls;

  // Per-byte state update
  always_comb begin
    mode_next           = mode;
    header_seen_next    = header_seen;
    run_length_next     = run_length;
    run_start_next      = run_start;
    base_counts_next    = base_counts;
    special_total_next  = special_total;
    emitted_length_next = emitted_length;
    error_latch_next    = error_latch;
    take_special        = 1'b0;
    sym_valid           = 1'b0;
    sym_code            = CODE_NONE;
    range_valid         = 1'b0;
    range_start         = '0;
    range_length        = '0;

    if (!error_latch) begin
      case (mode)
        MODE_HEADER: begin
          if (rd.op.is_nl) mode_next = MODE_START;
        end
        MODE_START, MODE_SEQ: begin
          if (mode == MODE_START && rd.op.is_gt) begin
            // header line; later headers emit a separator
            if (header_seen) begin
              take_special = 1'b1;
              sym_valid    = 1'b1;
              sym_code     = CODE_SEP;
            end
            header_seen_next = 1'b1;
            mode_next        = MODE_HEADER;
          end else if (rd.op.is_nl) begin
            mode_next = MODE_START;
          end else begin
            mode_next = MODE_SEQ;
            case (rd.op.cls)
              CLS_BAD: error_latch_next = 1'b1;
              CLS_WILD: begin
                take_special = 1'b1;
                sym_valid    = 1'b1;
                sym_code     = CODE_WILD;
              end
              CLS_A, CLS_C, CLS_G, CLS_T: begin
                base_counts_next[cls_bits[1:0]] = sat_inc(base_counts[cls_bits[1:0]]);
                // a base closes any open special run
                if (run_length != '0) begin
                  range_valid  = 1'b1;
                  range_start  = run_start;
                  range_length = run_length;
                end
                run_length_next     = '0;
                emitted_length_next = sat_inc(emitted_length);
                sym_valid           = 1'b1;
                sym_code            = cls_bits;
              end
              default: ; // whitespace is skipped
            endcase
          end
        end
        default: ;
      endcase
    end

    // wildcard or separator extends the special run
    if (take_special) begin
      if (run_length == '0) run_start_next = emitted_length;
      run_length_next     = sat_inc(run_length);
      special_total_next  = sat_inc(special_total);
      emitted_length_next = sat_inc(emitted_length);
    end
  end

  // Result fields, taken after this byte
  always_comb begin
    res_next.sym_valid     = sym_valid;
    res_next.sym_code      = sym_code;
    res_next.range_valid   = range_valid;
    res_next.range_start   = FIELD_BITS'(range_start);
    res_next.range_length  = FIELD_BITS'(range_length);
    res_next.error         = error_latch_next;
    res_next.count_a       = FIELD_BITS'(base_counts_next[0]);
    res_next.count_c       = FIELD_BITS'(base_counts_next[1]);
    res_next.count_g       = FIELD_BITS'(base_counts_next[2]);
    res_next.count_t       = FIELD_BITS'(base_counts_next[3]);
    res_next.special_count = FIELD_BITS'(special_total_next);
    res_next.total_length  = FIELD_BITS'(emitted_length_next);
  end

  // State registers; the last byte of a file returns everything to reset values
  always_ff @(posedge clk) begin
    if (rst || (pop && rd.op.last)) begin
      mode           <= MODE_START;
      header_seen    <= 1'b0;
      run_length     <= '0;
      run_start      <= '0;
      base_counts    <= '{default: '0};
      special_total  <= '0;
      emitted_length <= '0;
      error_latch    <= 1'b0;
    end else if (pop) begin
      mode           <= mode_next;
      header_seen    <= header_seen_next;
      run_length     <= run_length_next;
      run_start      <= run_start_next;
      base_counts    <= base_counts_next;
      special_total  <= special_total_next;
      emitted_length <= emitted_length_next;
      error_latch    <= error_latch_next;
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (symbols.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) res <= res_next;
  end

  assign symbols.valid         = out_valid;
  assign symbols.sym_valid     = res.sym_valid;
  assign symbols.sym_code      = res.sym_code;
  assign symbols.range_valid   = res.range_valid;
  assign symbols.range_start   = res.range_start;
  assign symbols.range_length  = res.range_length;
  assign symbols.error         = res.error;
  assign symbols.count_a       = res.count_a;
  assign symbols.count_c       = res.count_c;
  assign symbols.count_g       = res.count_g;
  assign symbols.count_t       = res.count_t;
  assign symbols.special_count = res.special_count;
  assign symbols.total_length  = res.total_length;

  // A closed run is always reported together with the base that closed it
  a_range_with_base: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.range_valid |-> res.sym_valid && (res.sym_code < CODE_WILD))
    else $error("range reported without a closing base");

  // A reported run is never empty
  a_range_nonempty: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.range_valid |-> res.range_length != '0)
    else $error("empty special run reported");

  // Once in error, a byte changes neither the flag nor the position
  a_error_frozen: assert property (@(posedge clk) disable iff (rst)
    pop && error_latch && !rd.op.last |=> error_latch && $stable(emitted_length))
    else $error("state moved while in error");

  // End of file returns the state to its start
  a_eof_clears: assert property (@(posedge clk) disable iff (rst)
    pop && rd.op.last |=> (mode == MODE_START) && !error_latch && (emitted_length == '0))
    else $error("state not cleared after last byte");

endmodule
